>>> rtl/bege_pkg.sv
// Shared types and codes for the breakpoint envelope generator.
// No dependencies; imported by breakpoint_envelope_generator and bege_interp.
`default_nettype none

package bege_pkg;

	// fixed field widths
	localparam int ACTION_W    = 2;
	localparam int ENTRY_W     = 4;
	localparam int SEG_COUNT_W = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;

	// table size; entry_index and segment_count widths are sized for it
	localparam int MAX_SEGMENTS = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK     = 2'd0,
		ACT_LEVEL    = 2'd1,
		ACT_DURATION = 2'd2,
		ACT_TRIGGER  = 2'd3
	} bege_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEGMENT_COUNT = 1'b0,
		REG_LOOP_ENABLE   = 1'b1
	} bege_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRIG,
		S_ADV,
		S_END,
		S_RD,
		S_RD2,
		S_RD3,
		S_WAIT,
		S_EMIT
	} bege_state_t;

	typedef enum logic [1:0] {
		IP_IDLE,
		IP_MUL,
		IP_DIV,
		IP_OUT
	} bege_ip_state_t;

endpackage

`default_nettype wire

>>> rtl/breakpoint_envelope_generator.sv
// Breakpoint envelope generator top level: sequencer, segment state, tables.
// Depends on bege_pkg, bege_ram, bege_interp.
//
// Every input word returns exactly one output word. Level and duration tables
// sit in two RAMs written straight from the input word; segment position and the
// current level are registers. Table writes and ticks with no run active go
// straight to the output; a trigger reads the start level, a tick that ends or
// wraps a run reads the duration, then the final level. A tick inside a run does
// three table reads, one multiply, then the bit-serial divider producing one
// quotient bit per cycle; a zero-duration segment skips multiply and divider.
// The next word is taken once the result reaches the output register; it may
// still be waiting there.
`default_nettype none

module breakpoint_envelope_generator
	import bege_pkg::*;
#(
	parameter int LEVEL_BITS   = 16,
	parameter int TIME_BITS    = 16,
	localparam int IN_W  = ((ENTRY_W + LEVEL_BITS + TIME_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((LEVEL_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// entry_index, level_data, duration_data, zero pad
	input  wire logic [IN_W-1:0]       s_axis_tdata,
	// action
	input  wire logic [ACTION_W-1:0]   s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// level_out, zero pad
	output logic [OUT_W-1:0]           m_axis_tdata,
	// running
	output logic                       m_axis_tuser,
	// finished
	output logic                       m_axis_tlast
);

	localparam int LB  = LEVEL_BITS;
	localparam int TB  = TIME_BITS;
	localparam int LAW = $clog2(MAX_SEGMENTS + 1);
	localparam int DAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	bege_state_t state_q, state_d;

	logic [SEG_COUNT_W-1:0] seg_count_q;
	logic                   loop_q;
	logic [DAW-1:0]         seg_q;
	logic [TB:0]            elapsed_q;
	logic                   active_q;
	logic                   fin_q;
	logic signed [LB-1:0]   cur_q;
	logic signed [LB-1:0]   a_q;
	logic [TB-1:0]          d_q;

	logic                   m_valid_q;
	logic [LB-1:0]          out_level_q;
	logic                   out_run_q, out_fin_q;

	// input word fields
	logic [ENTRY_W-1:0]     entry_index;
	logic [LB-1:0]          level_data;
	logic [TB-1:0]          duration_data;
	bege_action_t           action;

	logic                   in_acc, out_fire;
	logic                   lvl_we, dur_we, lvl_re, dur_re;
	logic [LAW-1:0]         lvl_raddr, n_used;
	logic [LB-1:0]          lvl_rdata;
	logic [TB-1:0]          dur_rdata;
	logic [TB:0]            elapsed_inc;
	logic                   past_end, last_seg;
	logic                   ip_start, ip_done;
	logic signed [LB-1:0]   ip_result;

	assign entry_index   = s_axis_tdata[ENTRY_W-1:0];
	assign level_data    = s_axis_tdata[ENTRY_W +: LB];
	assign duration_data = s_axis_tdata[ENTRY_W + LB +: TB];
	assign action        = bege_action_t'(s_axis_tuser);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_fire      = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);

	always_comb begin
		if (seg_count_q == '0) begin
			n_used = LAW'(1);
		end else if (32'(seg_count_q) > MAX_SEGMENTS) begin
			n_used = LAW'(MAX_SEGMENTS);
		end else begin
			n_used = LAW'(seg_count_q);
		end
	end

	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + (TB + 1)'(1);
	assign past_end    = elapsed_inc > {1'b0, dur_rdata};
	assign last_seg    = ({1'b0, LAW'(seg_q)} + (LAW + 1)'(1)) >= {1'b0, n_used};

	bege_ram #(
		.WIDTH (LB),
		.DEPTH (MAX_SEGMENTS + 1)
	) u_level_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (LAW'(entry_index)),
		.wdata (level_data),
		.re    (lvl_re),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	bege_ram #(
		.WIDTH (TB),
		.DEPTH (MAX_SEGMENTS)
	) u_duration_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (DAW'(entry_index)),
		.wdata (duration_data),
		.re    (dur_re),
		.raddr (seg_q),
		.rdata (dur_rdata)
	);

	bege_interp #(
		.LEVEL_BITS (LB),
		.TIME_BITS  (TB)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ip_start),
		.a      (a_q),
		.b      (lvl_rdata),
		.d      (d_q),
		.e      (elapsed_q),
		.done   (ip_done),
		.result (ip_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		lvl_we    = 1'b0;
		dur_we    = 1'b0;
		lvl_re    = 1'b0;
		dur_re    = 1'b0;
		lvl_raddr = '0;
		ip_start  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (action)
						ACT_LEVEL: begin
							lvl_we  = 32'(entry_index) <= MAX_SEGMENTS;
							state_d = S_EMIT;
						end
						ACT_DURATION: begin
							dur_we  = 32'(entry_index) < MAX_SEGMENTS;
							state_d = S_EMIT;
						end
						ACT_TRIGGER: begin
							lvl_re  = 1'b1;
							state_d = S_TRIG;
						end
						default: begin
							if (active_q) begin
								dur_re  = 1'b1;
								state_d = S_ADV;
							end else begin
								state_d = S_EMIT;
							end
						end
					endcase
				end
			end
			S_TRIG: state_d = S_EMIT;
			S_ADV: begin
				if (past_end && last_seg) begin
					lvl_re    = 1'b1;
					lvl_raddr = n_used;
					state_d   = S_END;
				end else begin
					state_d = S_RD;
				end
			end
			S_END: state_d = S_EMIT;
			S_RD: begin
				dur_re    = 1'b1;
				lvl_re    = 1'b1;
				lvl_raddr = LAW'(seg_q);
				state_d   = S_RD2;
			end
			S_RD2: begin
				lvl_re    = 1'b1;
				lvl_raddr = LAW'(seg_q) + LAW'(1);
				state_d   = S_RD3;
			end
			S_RD3: begin
				ip_start = 1'b1;
				state_d  = S_WAIT;
			end
			S_WAIT: begin
				if (ip_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEG_COUNT_W'(1);
			loop_q      <= 1'b0;
		end else if (cfg_we) begin
			case (bege_reg_t'(cfg_index))
				REG_SEGMENT_COUNT: seg_count_q <= cfg_data;
				REG_LOOP_ENABLE:   loop_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= '0;
			elapsed_q <= '0;
			active_q  <= 1'b0;
			fin_q     <= 1'b0;
			cur_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_TRIG: begin
					cur_q     <= lvl_rdata;
					active_q  <= 1'b1;
					seg_q     <= '0;
					elapsed_q <= '0;
				end
				S_ADV: begin
					if (!past_end) begin
						elapsed_q <= elapsed_inc;
					end else if (!last_seg) begin
						// carry the excess into the next segment
						elapsed_q <= elapsed_inc - {1'b0, dur_rdata};
						seg_q     <= seg_q + DAW'(1);
					end
				end
				S_END: begin
					cur_q     <= lvl_rdata;
					seg_q     <= '0;
					elapsed_q <= '0;
					if (!loop_q) begin
						active_q <= 1'b0;
						fin_q    <= 1'b1;
					end
				end
				S_WAIT: begin
					if (ip_done) begin
						cur_q <= ip_result;
					end
				end
				S_EMIT: begin
					if (out_fire) begin
						fin_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD2) begin
			a_q <= lvl_rdata;
			d_q <= dur_rdata;
		end
		if (out_fire) begin
			out_level_q <= cur_q;
			out_run_q   <= active_q;
			out_fin_q   <= fin_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'(out_level_q);
	assign m_axis_tuser  = out_run_q;
	assign m_axis_tlast  = out_fin_q;

	a_fin_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
		else $error("finished word shows running");

	a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("second word taken before result");

	a_idle_position_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (seg_q == '0) && (elapsed_q == '0))
		else $error("segment position set with no run");

	a_interp_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ip_done |-> state_q == S_WAIT)
		else $error("interpolator finished outside wait state");

endmodule

`default_nettype wire

>>> rtl/bege_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bege_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/bege_interp.sv
// Segment interpolator: a +/- trunc(|b-a| * e / d), with e clamped to d.
// One multiply, then a restoring divider retiring one quotient bit per cycle.
// Depends on bege_pkg.
`default_nettype none

module bege_interp
	import bege_pkg::*;
#(
	parameter int LEVEL_BITS = 16,
	parameter int TIME_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [LEVEL_BITS-1:0] a,
	input  wire logic signed [LEVEL_BITS-1:0] b,
	input  wire logic        [TIME_BITS-1:0]  d,
	input  wire logic        [TIME_BITS:0]    e,
	output logic                              done,
	output logic signed      [LEVEL_BITS-1:0] result
);

	localparam int LB    = LEVEL_BITS;
	localparam int TB    = TIME_BITS;
	localparam int CNT_W = $clog2(LB);

	bege_ip_state_t state_q, state_d;

	logic signed [LB-1:0]   a_q, b_q;
	logic        [TB-1:0]   d_q, e_q, rem_q;
	logic        [LB-1:0]   mag_q, quo_q;
	logic                   neg_q, zero_q;
	logic        [CNT_W-1:0] cnt_q;

	logic signed [LB:0]  diff;
	logic        [LB:0]  diff_abs;
	logic        [LB+TB-1:0] prod;
	logic        [TB:0]  trial;
	logic                fits;
	logic signed [LB:0]  sum;

	assign diff     = {b[LB-1], b} - {a[LB-1], a};
	assign diff_abs = diff[LB] ? -diff : diff;
	assign prod     = mag_q * e_q;
	assign trial    = {rem_q, quo_q[LB-1]};
	assign fits     = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			IP_IDLE: begin
				if (start) begin
					state_d = (d == '0) ? IP_OUT : IP_MUL;
				end
			end
			IP_MUL: state_d = IP_DIV;
			IP_DIV: begin
				if (cnt_q == CNT_W'(LB - 1)) begin
					state_d = IP_OUT;
				end
			end
			IP_OUT: begin
				done    = 1'b1;
				state_d = IP_IDLE;
			end
			default: state_d = IP_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IP_IDLE: begin
				if (start) begin
					a_q    <= a;
					b_q    <= b;
					d_q    <= d;
					e_q    <= (e < {1'b0, d}) ? e[TB-1:0] : d;
					neg_q  <= diff[LB];
					mag_q  <= diff_abs[LB-1:0];
					zero_q <= (d == '0);
				end
			end
			IP_MUL: begin
				// product < d * 2^LB, so the high part already sits below d
				rem_q <= prod[LB+TB-1:LB];
				quo_q <= prod[LB-1:0];
				cnt_q <= '0;
			end
			IP_DIV: begin
				rem_q <= fits ? TB'(trial - {1'b0, d_q}) : trial[TB-1:0];
				quo_q <= {quo_q[LB-2:0], fits};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign sum = neg_q ? ({a_q[LB-1], a_q} - {1'b0, quo_q})
	                   : ({a_q[LB-1], a_q} + {1'b0, quo_q});
	assign result = zero_q ? b_q : sum[LB-1:0];

endmodule

`default_nettype wire

>>> tb/tb_breakpoint_envelope_generator.sv
// Self-checking testbench for breakpoint_envelope_generator.
// Drives table writes, triggers and ticks over the input stream and checks each
// output word against a bench predictor or a fixed word. Depends on bege_pkg.
`timescale 1ns / 100ps

module tb_breakpoint_envelope_generator;
	import bege_pkg::*;

	localparam int MAX_SEG     = 8;
	localparam int WATCH_LIMIT = 5000;
	localparam int SETTLE      = 30;
	localparam int HOLD_CYCLES = 400;
	localparam logic [16:0] ELAPSED_TOP = 17'h1FFFF;

	typedef struct packed {
		logic signed [15:0] level;
		logic               running;
		logic               finished;
	} env_word_t;

	typedef struct {
		bit        fixed;
		env_word_t word;
	} known_word_t;

	typedef struct {
		bege_action_t act;
		logic [3:0]   idx;
		logic [15:0]  lvl;
		logic [15:0]  dur;
		bit           fixed;
		env_word_t    word;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// entry_index, level_data, duration_data, zero pad
	logic [39:0]           s_axis_tdata = '0;
	// action
	logic [ACTION_W-1:0]   s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// level_out, zero pad
	logic [15:0]           m_axis_tdata;
	// running
	logic                  m_axis_tuser;
	// finished
	logic                  m_axis_tlast;

	breakpoint_envelope_generator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// predictor state
	logic signed [15:0] lvl_tab [0:MAX_SEG];
	logic [15:0]        dur_tab [0:MAX_SEG-1];
	logic [3:0]         seg_idx = '0;
	logic [16:0]        seg_elapsed = '0;
	bit                 run_active = 1'b0;
	logic signed [15:0] env_level = '0;
	logic [3:0]         seg_count_cfg = 4'd1;
	bit                 loop_cfg = 1'b0;

	env_word_t   envelope_q [$];
	known_word_t known_q [$];
	stim_row_t   directed_rows [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;

	function automatic logic signed [15:0] segment_level();
		int unsigned s;
		longint a, b, d, e, q;
		s = (seg_idx >= MAX_SEG) ? MAX_SEG - 1 : seg_idx;
		a = lvl_tab[s];
		b = lvl_tab[s + 1];
		d = dur_tab[s];
		if (d == 0)
			return lvl_tab[s + 1];
		e = (seg_elapsed < d) ? seg_elapsed : d;
		if (b >= a) begin
			q = ((b - a) * e) / d;
			return 16'(a + q);
		end
		q = ((a - b) * e) / d;
		return 16'(a - q);
	endfunction

	function automatic env_word_t envelope_step(bege_action_t act, logic [3:0] idx,
			logic [15:0] lvl, logic [15:0] dur);
		env_word_t w;
		int unsigned s, n;
		logic [15:0] d;
		bit done;
		done = 1'b0;
		case (act)
			ACT_LEVEL: begin
				if (idx <= MAX_SEG)
					lvl_tab[idx] = lvl;
			end
			ACT_DURATION: begin
				if (idx < MAX_SEG)
					dur_tab[idx] = dur;
			end
			ACT_TRIGGER: begin
				run_active = 1'b1;
				seg_idx = '0;
				seg_elapsed = '0;
				env_level = lvl_tab[0];
			end
			default: begin
				if (run_active) begin
					s = (seg_idx >= MAX_SEG) ? MAX_SEG - 1 : seg_idx;
					d = dur_tab[s];
					if (seg_elapsed != ELAPSED_TOP)
						seg_elapsed = seg_elapsed + 1'b1;
					if (seg_elapsed > d) begin
						n = (seg_count_cfg == 0) ? 1 :
							(seg_count_cfg > MAX_SEG) ? MAX_SEG : seg_count_cfg;
						if (s + 1 >= n) begin
							// run ends: hold the final breakpoint, maybe wrap
							env_level = lvl_tab[n];
							seg_idx = '0;
							seg_elapsed = '0;
							if (!loop_cfg) begin
								run_active = 1'b0;
								done = 1'b1;
							end
						end else begin
							seg_elapsed = seg_elapsed - d;
							seg_idx = 4'(s + 1);
							env_level = segment_level();
						end
					end else begin
						env_level = segment_level();
					end
				end
			end
		endcase
		w.level = env_level;
		w.running = run_active;
		w.finished = done;
		return w;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// scoreboard and watchdog count
	always @(posedge clk) begin
		env_word_t want, pred;
		known_word_t k;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (envelope_q.size() == 0) begin
					$error("unexpected output word: level_out %0d",
						$signed(m_axis_tdata));
					mismatches++;
				end else begin
					want = envelope_q.pop_front();
					if (m_axis_tdata !== want.level) begin
						$error("level_out: expected %0d, got %0d",
							$signed(want.level), $signed(m_axis_tdata));
						mismatches++;
					end
					if (m_axis_tuser !== want.running) begin
						$error("running: expected %0b, got %0b", want.running, m_axis_tuser);
						mismatches++;
					end
					if (m_axis_tlast !== want.finished) begin
						$error("finished: expected %0b, got %0b",
							want.finished, m_axis_tlast);
						mismatches++;
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(envelope_q.size() == 0 && !s_axis_tvalid))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (s_axis_tvalid && s_axis_tready) begin
				pred = envelope_step(bege_action_t'(s_axis_tuser), s_axis_tdata[3:0],
					s_axis_tdata[19:4], s_axis_tdata[35:20]);
				k = known_q.pop_front();
				envelope_q.push_back(k.fixed ? k.word : pred);
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCH_LIMIT)
			@(posedge clk);
		$display("FAIL breakpoint_envelope_generator");
		$finish;
	end

	// output side back-pressure
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!steady) begin
				g = idle_gap();
				if (g != 0) begin
					m_axis_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(0, 3)) @(posedge clk);
		end
	end

	task automatic send_word(bege_action_t act, logic [3:0] idx, logic [15:0] lvl,
			logic [15:0] dur, bit fixed, env_word_t word);
		known_word_t k;
		int g;
		g = steady ? 0 : idle_gap();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		k.fixed = fixed;
		k.word = word;
		known_q.push_back(k);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, dur, lvl, idx};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic add_row(bege_action_t act, logic [3:0] idx, logic [15:0] lvl,
			logic [15:0] dur, bit fixed, logic [15:0] lvl_exp, bit run_exp, bit fin_exp);
		stim_row_t r;
		r.act = act;
		r.idx = idx;
		r.lvl = lvl;
		r.dur = dur;
		r.fixed = fixed;
		r.word = {lvl_exp, run_exp, fin_exp};
		directed_rows.push_back(r);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (envelope_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_register(bege_reg_t r, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (r == REG_SEGMENT_COUNT)
			seg_count_cfg = v;
		else
			loop_cfg = v[0];
	endtask

	task automatic random_word();
		int r;
		bege_action_t act;
		logic [3:0] idx;
		logic [15:0] lvl, dur;
		r = $urandom_range(0, 99);
		act = (r < 68) ? ACT_TICK : (r < 75) ? ACT_TRIGGER :
			(r < 87) ? ACT_LEVEL : ACT_DURATION;
		idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(0, 8));
		if ($urandom_range(0, 9) == 0)
			lvl = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		else
			lvl = 16'($urandom_range(0, 65535));
		// mostly short segments so runs advance, wrap and end
		dur = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(0, 65535)) :
			16'($urandom_range(0, 4));
		send_word(act, idx, lvl, dur, 1'b0, '0);
	endtask

	initial begin
		logic [3:0] counts [0:7];
		bit loops [0:7];
		counts = '{4'd2, 4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd8};
		loops = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, default config: one segment, no looping
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 1, 16'h0000, 0, 0);
		add_row(ACT_LEVEL,    4'd0,  16'h8000, 16'h0000, 1, 16'h0000, 0, 0);
		add_row(ACT_LEVEL,    4'd1,  16'h7FFF, 16'h0000, 1, 16'h0000, 0, 0);
		add_row(ACT_DURATION, 4'd0,  16'h0000, 16'h0000, 1, 16'h0000, 0, 0);
		add_row(ACT_TRIGGER,  4'd0,  16'h0000, 16'h0000, 1, 16'h8000, 1, 0);
		// zero duration jumps to the end level and ends the run
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 1, 16'h7FFF, 0, 1);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 1, 16'h7FFF, 0, 0);
		add_row(ACT_DURATION, 4'd0,  16'h0000, 16'h0003, 1, 16'h7FFF, 0, 0);
		add_row(ACT_TRIGGER,  4'd0,  16'h0000, 16'h0000, 1, 16'h8000, 1, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 1, 16'h7FFF, 0, 1);
		// out-of-range table writes are dropped
		add_row(ACT_LEVEL,    4'd9,  16'h5555, 16'h0000, 1, 16'h7FFF, 0, 0);
		add_row(ACT_LEVEL,    4'd15, 16'hAAAA, 16'hFFFF, 1, 16'h7FFF, 0, 0);
		add_row(ACT_DURATION, 4'd8,  16'h0000, 16'hFFFF, 1, 16'h7FFF, 0, 0);
		add_row(ACT_DURATION, 4'd15, 16'hFFFF, 16'hAAAA, 1, 16'h7FFF, 0, 0);
		// falling slope over the longest duration
		add_row(ACT_LEVEL,    4'd1,  16'h8000, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_LEVEL,    4'd0,  16'h7FFF, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_DURATION, 4'd0,  16'h0000, 16'hFFFF, 0, 16'h0000, 0, 0);
		add_row(ACT_TRIGGER,  4'd0,  16'h0000, 16'h0000, 1, 16'h7FFF, 1, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_TRIGGER,  4'd0,  16'h0000, 16'h0000, 1, 16'h7FFF, 1, 0);
		// shorten the running segment mid-run
		add_row(ACT_DURATION, 4'd0,  16'h0000, 16'h0001, 0, 16'h0000, 0, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 0, 16'h0000, 0, 0);
		add_row(ACT_TICK,     4'd0,  16'h0000, 16'h0000, 1, 16'h8000, 0, 1);

		foreach (directed_rows[i])
			send_word(directed_rows[i].act, directed_rows[i].idx, directed_rows[i].lvl,
				directed_rows[i].dur, directed_rows[i].fixed, directed_rows[i].word);

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			set_register(REG_SEGMENT_COUNT, counts[p]);
			set_register(REG_LOOP_ENABLE, {3'b0, loops[p]});
			steady = (p == 3);
			if (p == 2)
				hold_req = 1'b1;
			if (p == 0) begin
				// fill every table entry before any run can reach it
				for (int i = 0; i <= MAX_SEG; i++)
					send_word(ACT_LEVEL, 4'(i), 16'($urandom_range(0, 65535)), 16'h0000,
						1'b0, '0);
				for (int i = 0; i < MAX_SEG; i++)
					send_word(ACT_DURATION, 4'(i), 16'h0000, 16'($urandom_range(0, 4)),
						1'b0, '0);
			end
			repeat (50) random_word();
		end

		wait_drained();
		if (mismatches == 0)
			$display("PASS breakpoint_envelope_generator");
		else
			$display("FAIL breakpoint_envelope_generator");
		$finish;
	end

endmodule
